// ===== rtl/sfs_pkg.sv =====
// Shared types and constants for the sprite frame scanner.
// No dependencies; used by every module of the block.
package sfs_pkg;

  localparam int unsigned MAX_SIDE_DEF   = 2048;
  localparam logic [31:0] MARKER_PRI_RST = 32'd800;
  localparam logic [31:0] MARKER_SEC_RST = 32'd710;

  localparam int unsigned HDR_LEAD   = 20;
  localparam int unsigned HDR_BYTES  = 16;
  localparam int unsigned WIN_W      = 8 * HDR_BYTES;
  localparam int unsigned FILL_W     = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SIDE_OUT_W = 12;
  localparam int unsigned INDEX_W    = 22;
  localparam int unsigned LEFT_W     = 23;
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned OUT_TDATA_W = 96;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOB_LENGTH = 2'd0,
    REG_MARKER_PRI  = 2'd1,
    REG_MARKER_SEC  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PHASE_BLUE  = 2'd0,
    PHASE_GREEN = 2'd1,
    PHASE_RED   = 2'd2,
    PHASE_ALPHA = 2'd3
  } phase_t;

  typedef struct packed {
    logic [31:0] blob_length;
    logic [31:0] marker_primary;
    logic [31:0] marker_secondary;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } step_t;

  typedef struct packed {
    logic                  hit;
    logic [SIDE_OUT_W-1:0] width;
    logic [SIDE_OUT_W-1:0] height;
    logic [LEFT_W-1:0]     pixels;
  } hdr_t;

  typedef struct packed {
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            alpha;
    logic [SIDE_OUT_W-1:0] frame_width;
    logic [SIDE_OUT_W-1:0] frame_height;
    logic [INDEX_W-1:0]    pixel_index;
    logic                  first_pixel;
    logic                  last_pixel;
    logic [FRAME_W-1:0]    frame_number;
  } pixel_t;

endpackage

// ===== rtl/sfs_hdr_check.sv =====
// Frame header test on a 16-byte window of little-endian words.
// Depends on sfs_pkg.
module sfs_hdr_check #(
  parameter int unsigned MAX_SIDE = sfs_pkg::MAX_SIDE_DEF
) (
  input  logic [sfs_pkg::WIN_W-1:0] win,
  input  logic [31:0]               pos,
  input  sfs_pkg::cfg_t             cfg,
  output sfs_pkg::hdr_t             hdr
);

  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned PROD_W = 2 * SIDE_W;
  localparam int unsigned CMP_W  = (PROD_W + 2 > 34) ? PROD_W + 2 : 34;

  logic [31:0]       ver;
  logic [31:0]       w;
  logic [31:0]       h;
  logic [31:0]       dlen;
  logic [31:0]       j;
  logic [PROD_W-1:0] prod;
  logic              ver_ok;
  logic              side_ok;
  logic              len_ok;
  logic              lead_ok;
  logic              fit_ok;

  assign ver  = win[31:0];
  assign w    = win[63:32];
  assign h    = win[95:64];
  assign dlen = win[127:96];
  assign j    = pos - 32'(sfs_pkg::HDR_BYTES - 1);
  assign prod = PROD_W'(w[SIDE_W-1:0]) * PROD_W'(h[SIDE_W-1:0]);

  always_comb begin
    ver_ok  = (ver == cfg.marker_primary) || (ver == cfg.marker_secondary);
    side_ok = (w != 32'd0) && (h != 32'd0) &&
              (w <= 32'(MAX_SIDE)) && (h <= 32'(MAX_SIDE));
    len_ok  = (CMP_W'({prod, 2'b00}) == CMP_W'(dlen));
    lead_ok = ((33'(j) + 33'(sfs_pkg::HDR_LEAD)) < 33'(cfg.blob_length));
    fit_ok  = ((34'(j) + 34'(sfs_pkg::HDR_BYTES) + 34'(dlen)) <= 34'(cfg.blob_length));
    hdr.hit    = ver_ok && side_ok && len_ok && lead_ok && fit_ok;
    hdr.width  = w[sfs_pkg::SIDE_OUT_W-1:0];
    hdr.height = h[sfs_pkg::SIDE_OUT_W-1:0];
    hdr.pixels = sfs_pkg::LEFT_W'(prod);
  end

endmodule

// ===== rtl/sfs_core.sv =====
// Scan state, pixel assembly and result register of the frame scanner.
// Depends on sfs_pkg and sfs_hdr_check.
module sfs_core #(
  parameter int unsigned MAX_SIDE = sfs_pkg::MAX_SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  sfs_pkg::step_t   step,
  input  sfs_pkg::cfg_t    cfg,
  input  logic             res_ready,
  output logic             res_valid,
  output sfs_pkg::pixel_t  res
);

  logic [sfs_pkg::WIN_W-1:0]      win_r, win_nxt, win_shift;
  logic [sfs_pkg::FILL_W-1:0]     fill_r, fill_nxt, fill_cur, fill_inc;
  logic [31:0]                    pos_r, pos_nxt, pos_cur;
  logic                           inpix_r, inpix_nxt, inpix_cur;
  logic [sfs_pkg::SIDE_OUT_W-1:0] width_r, width_nxt;
  logic [sfs_pkg::SIDE_OUT_W-1:0] height_r, height_nxt;
  logic [sfs_pkg::LEFT_W-1:0]     left_r, left_nxt, left_dec;
  logic [sfs_pkg::INDEX_W-1:0]    count_r, count_nxt;
  sfs_pkg::phase_t                phase_r, phase_nxt, phase_cur;
  logic [23:0]                    part_r, part_nxt;
  logic [sfs_pkg::FRAME_W-1:0]    frames_r, frames_nxt;
  logic                           res_valid_r, res_valid_nxt;
  sfs_pkg::pixel_t                res_r, res_nxt;
  sfs_pkg::hdr_t                  hdr;

  assign win_shift = {step.data, win_r[sfs_pkg::WIN_W-1:8]};

  sfs_hdr_check #(.MAX_SIDE(MAX_SIDE)) u_hdr (
    .win (win_shift),
    .pos (pos_cur),
    .cfg (cfg),
    .hdr (hdr)
  );

  always_comb begin
    pos_cur   = step.start ? 32'd0 : pos_r;
    fill_cur  = step.start ? '0 : fill_r;
    inpix_cur = step.start ? 1'b0 : inpix_r;
    phase_cur = step.start ? sfs_pkg::PHASE_BLUE : phase_r;
    fill_inc  = (fill_cur == sfs_pkg::FILL_W'(sfs_pkg::HDR_BYTES)) ? fill_cur
                                                                   : fill_cur + 1'b1;
    left_dec  = left_r - 1'b1;

    win_nxt       = win_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    inpix_nxt     = inpix_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    left_nxt      = left_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    part_nxt      = part_r;
    frames_nxt    = frames_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;

    if (go) begin
      pos_nxt   = pos_cur + 32'd1;
      fill_nxt  = fill_cur;
      inpix_nxt = inpix_cur;
      phase_nxt = phase_cur;
      if (inpix_cur) begin
        case (phase_cur)
          sfs_pkg::PHASE_BLUE: begin
            part_nxt[7:0] = step.data;
            phase_nxt     = sfs_pkg::PHASE_GREEN;
          end
          sfs_pkg::PHASE_GREEN: begin
            part_nxt[15:8] = step.data;
            phase_nxt      = sfs_pkg::PHASE_RED;
          end
          sfs_pkg::PHASE_RED: begin
            part_nxt[23:16] = step.data;
            phase_nxt       = sfs_pkg::PHASE_ALPHA;
          end
          default: begin
            res_nxt.red          = part_r[23:16];
            res_nxt.green        = part_r[15:8];
            res_nxt.blue         = part_r[7:0];
            res_nxt.alpha        = step.data;
            res_nxt.frame_width  = width_r;
            res_nxt.frame_height = height_r;
            res_nxt.pixel_index  = count_r;
            res_nxt.first_pixel  = (count_r == '0);
            res_nxt.last_pixel   = (left_r == sfs_pkg::LEFT_W'(1));
            res_nxt.frame_number = frames_r;
            res_valid_nxt        = 1'b1;
            phase_nxt            = sfs_pkg::PHASE_BLUE;
            count_nxt            = count_r + 1'b1;
            left_nxt             = left_dec;
            if (left_dec == '0) begin
              inpix_nxt = 1'b0;
              fill_nxt  = '0;
            end
          end
        endcase
      end else begin
        win_nxt  = win_shift;
        fill_nxt = fill_inc;
        if ((fill_inc == sfs_pkg::FILL_W'(sfs_pkg::HDR_BYTES)) && hdr.hit) begin
          inpix_nxt  = 1'b1;
          width_nxt  = hdr.width;
          height_nxt = hdr.height;
          left_nxt   = hdr.pixels;
          count_nxt  = '0;
          phase_nxt  = sfs_pkg::PHASE_BLUE;
          frames_nxt = frames_r + 1'b1;
          fill_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pos_r       <= '0;
      inpix_r     <= 1'b0;
      width_r     <= '0;
      height_r    <= '0;
      left_r      <= '0;
      count_r     <= '0;
      phase_r     <= sfs_pkg::PHASE_BLUE;
      part_r      <= '0;
      frames_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      inpix_r     <= inpix_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      left_r      <= left_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      part_r      <= part_nxt;
      frames_r    <= frames_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== rtl/sprite_frame_scanner_top.sv =====
// Top level of the sprite frame scanner: input register, configuration
// registers and stream ports. Depends on sfs_pkg and sfs_core.
//
// Usage:
//   in_*   : one blob byte per transfer; in_tuser marks the first byte of a blob.
//   out_*  : one RGBA pixel with frame data per transfer; out_tlast marks the
//            last pixel of a frame, out_tuser the first.
//   cfg_*  : register writes (blob length, two header markers); cfg_ready is
//            always high. Write only while no byte is in flight.
// Result path: a result shows on out_tvalid once the fourth (alpha) byte of its
//   pixel has gone through the input register and into the result register.
// Throughput: one byte per cycle when not stalled, set by the combinational
//   header test (window compare plus one side-by-side multiply) between the
//   input and scan state registers; a w*h frame gives a pixel per four bytes.
// Reset: synchronous, active low; clears scan state, frame counter, both
//   valid flags and restores the register defaults.
// Stall: while out_tready is low and a result waits, the input register
//   holds one byte and in_tready drops; nothing is lost or repeated.
module sprite_frame_scanner_top #(
  parameter int unsigned MAX_SIDE = sfs_pkg::MAX_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // data_byte
  input  logic                              in_tuser,  // blob_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // red, green, blue, alpha, frame_width, frame_height, pixel_index,
  // frame_number, zero pad
  output logic [sfs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser, // first_pixel
  output logic                              out_tlast, // last_pixel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  logic            in_vld_r, in_vld_nxt;
  sfs_pkg::step_t  step_r, step_nxt;
  sfs_pkg::cfg_t   cfg_r, cfg_nxt;
  logic            go;
  logic            res_valid;
  sfs_pkg::pixel_t res;

  assign go        = in_vld_r && (!res_valid || out_tready);
  assign in_tready = !in_vld_r || go;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_vld_nxt = in_vld_r;
    step_nxt   = step_r;
    if (in_tready) begin
      in_vld_nxt = in_tvalid;
      step_nxt   = '{data: in_tdata, start: in_tuser};
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (sfs_pkg::cfg_reg_t'(cfg_index))
        sfs_pkg::REG_BLOB_LENGTH: cfg_nxt.blob_length      = cfg_data;
        sfs_pkg::REG_MARKER_PRI:  cfg_nxt.marker_primary   = cfg_data;
        sfs_pkg::REG_MARKER_SEC:  cfg_nxt.marker_secondary = cfg_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      cfg_r    <= '{blob_length:      32'd0,
                    marker_primary:   sfs_pkg::MARKER_PRI_RST,
                    marker_secondary: sfs_pkg::MARKER_SEC_RST};
    end else begin
      in_vld_r <= in_vld_nxt;
      cfg_r    <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
  end

  sfs_core #(.MAX_SIDE(MAX_SIDE)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .step      (step_r),
    .cfg       (cfg_r),
    .res_ready (out_tready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_tvalid = res_valid;
  assign out_tuser  = res.first_pixel;
  assign out_tlast  = res.last_pixel;
  assign out_tdata  = {2'b00, res.frame_number, res.pixel_index, res.frame_height,
                       res.frame_width, res.alpha, res.blue, res.green, res.red};

endmodule

// ===== rtl/sfs_checker.sv =====
// Port-level checks for the sprite frame scanner, bound to the top level.
// Depends on sfs_pkg and sprite_frame_scanner_top.
module sfs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sfs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[77:56] == 22'd0)))
    else $error("first pixel flag disagrees with pixel index");

  a_stall_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_stall_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind sprite_frame_scanner_top sfs_checker u_sfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
